// ===== rtl/id_to_slot_mapping_table_assert.svh =====
// Assertion macros for the id-to-slot mapping table.
// Used inside modules that have clk and rst in scope; no other dependencies.
`ifndef ID_TO_SLOT_MAPPING_TABLE_ASSERT_SVH
`define ID_TO_SLOT_MAPPING_TABLE_ASSERT_SVH

// Same-cycle implication.
`define IDSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IDSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/idsm_pkg.sv =====
// Package for the id-to-slot mapping table: opcodes, status codes, beat structs.
// No dependencies.
package idsm_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam logic [31:0] FREE_ID = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_FORGET  = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] unit_id;
    logic [5:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result_value;
    status_t     status;
    logic [15:0] slot_generation;
  } rsp_t;

  // One table slot as held in a cell.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] gen;
  } entry_t;

endpackage

// ===== rtl/idsm_cell.sv =====
// One slot cell of the rotating slot ring: holds an id and its generation.
// Depends on idsm_pkg.
module idsm_cell (
  input  logic            clk,
  input  logic            shift,
  input  idsm_pkg::entry_t d,
  output idsm_pkg::entry_t q
);
  import idsm_pkg::*;

  entry_t slot;

  // No reset: contents are only read below the high-water mark.
  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= d;
    end
  end

  assign q = slot;

endmodule

// ===== rtl/id_to_slot_mapping_table.sv =====
// Id-to-slot mapping table: a ring of SLOTS cells that rotates one slot per cycle
// while busy, past a head unit doing the compare/update. Depends on idsm_pkg,
// idsm_cell and id_to_slot_mapping_table_assert.svh.
//
// Usage: a command is taken when start is high and busy is low. Every command
// takes one full turn of the cell ring, which brings each slot past the head
// unit once; the result appears on result with done high for one cycle, both
// registered as the turn ends. busy drops in that same cycle, so the next
// command may start while done is high. The receiver cannot stall; results
// must be taken when done is high. networked_mode is written through
// cfg_valid/cfg_data (cfg_ready is always high) and must only change while
// busy is low. No clearing pass after reset.
module id_to_slot_mapping_table #(
  parameter int SLOTS = idsm_pkg::SLOTS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  idsm_pkg::cmd_t cmd,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  output logic          done,
  output idsm_pkg::rsp_t result
);
  import idsm_pkg::*;

  localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = $clog2(SLOTS + 1);

  entry_t          cell_q [SLOTS];
  entry_t          tail;
  entry_t          head;
  logic [PW-1:0]   pos;
  logic [MW-1:0]   mark;
  logic [MW-1:0]   mark_next;
  logic            found;
  logic            found_next;
  logic            networked_mode;
  logic            last;
  logic            in_range;
  logic            accept;
  cmd_t            cmd_q;
  logic [31:0]     val_q;
  logic [31:0]     val_next;
  logic [15:0]     gen_q;
  logic [15:0]     gen_next;
  rsp_t            rsp_next;

  // Ring: cell i loads from cell i+1, the last cell loads the head's updated entry.
  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    if (i == SLOTS - 1) begin : g_tail
      idsm_cell u_cell (.clk(clk), .shift(busy), .d(tail), .q(cell_q[i]));
    end else begin : g_mid
      idsm_cell u_cell (.clk(clk), .shift(busy), .d(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  assign head      = cell_q[0];
  assign accept    = start && !busy;
  assign last      = (pos == PW'(SLOTS - 1));
  assign in_range  = (32'(pos) < 32'(mark));
  assign cfg_ready = 1'b1;

  // Head unit: slot number pos sits in cell 0 during this cycle.
  always_comb begin
    tail       = head;
    found_next = found;
    val_next   = val_q;
    gen_next   = gen_q;
    mark_next  = mark;
    case (cmd_q.opcode)
      OP_ADD: begin
        if (!found) begin
          if (in_range && head.id == FREE_ID) begin
            tail.id    = cmd_q.unit_id;
            tail.gen   = head.gen + 16'd1;
            found_next = 1'b1;
            val_next   = 32'(pos);
            gen_next   = head.gen + 16'd1;
          end else if (32'(pos) == 32'(mark)) begin
            // nothing free below the mark: append here
            tail.id    = cmd_q.unit_id;
            tail.gen   = '0;
            mark_next  = mark + MW'(1);
            found_next = 1'b1;
            val_next   = 32'(pos);
            gen_next   = '0;
          end
        end
      end
      OP_FORGET: begin
        if (!found && in_range && head.id == cmd_q.unit_id) begin
          tail.id    = FREE_ID;
          found_next = 1'b1;
          val_next   = 32'(pos);
        end
      end
      OP_LOOKUP: begin
        if (!found && in_range && head.id == cmd_q.unit_id) begin
          found_next = 1'b1;
          val_next   = 32'(pos);
        end
      end
      OP_REVERSE: begin
        if (32'(pos) == 32'(cmd_q.slot_index) && in_range && head.id != FREE_ID) begin
          found_next = 1'b1;
          val_next   = head.id;
        end
      end
      default: begin
        found_next = found;
      end
    endcase

    rsp_next.result_value    = FREE_ID;
    rsp_next.status          = ST_MISS;
    rsp_next.slot_generation = '0;
    if (cmd_q.opcode == OP_LOOKUP && !networked_mode) begin
      rsp_next.result_value = cmd_q.unit_id;
      rsp_next.status       = ST_OK;
    end else if (found_next) begin
      rsp_next.result_value    = val_next;
      rsp_next.status          = ST_OK;
      rsp_next.slot_generation = gen_next;
    end else if (cmd_q.opcode == OP_ADD) begin
      rsp_next.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      done           <= 1'b0;
      pos            <= '0;
      mark           <= '0;
      found          <= 1'b0;
      networked_mode <= 1'b1;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        networked_mode <= cfg_data;
      end
      if (accept) begin
        busy  <= 1'b1;
        pos   <= '0;
        found <= 1'b0;
      end else if (busy) begin
        mark  <= mark_next;
        found <= found_next;
        if (last) begin
          pos  <= '0;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          pos <= pos + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      val_q <= FREE_ID;
      gen_q <= '0;
    end else if (busy) begin
      val_q <= val_next;
      gen_q <= gen_next;
      if (last) begin
        result <= rsp_next;
      end
    end
  end

`include "id_to_slot_mapping_table_assert.svh"

  `IDSM_ASSERT_NOW(a_mark_bound, 1'b1, 32'(mark) <= 32'(SLOTS), "mark above SLOTS")
  `IDSM_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while scanning")
  `IDSM_ASSERT_NEXT(a_start_busy, accept, busy && pos == '0, "command not started")
  `IDSM_ASSERT_NOW(a_full_mark, done && result.status == ST_FULL, 32'(mark) == 32'(SLOTS) && result.result_value == FREE_ID, "full reported below capacity")
  `IDSM_ASSERT_NEXT(a_mark_step, busy && !accept, mark == $past(mark) || mark == $past(mark) + MW'(1), "mark moved by more than one")

endmodule

// ===== bench/id_to_slot_mapping_table_checker.sv =====
`timescale 1ns / 100ps
// Checker for the id-to-slot mapping table: watches command, config and result beats,
// keeps its own copy of the slot table and compares each result beat. Depends on idsm_pkg.
module id_to_slot_mapping_table_checker #(
  parameter int SLOTS = idsm_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  idsm_pkg::cmd_t cmd,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           done,
  input  idsm_pkg::rsp_t result,
  output int             fail_count,
  output int             outstanding
);
  import idsm_pkg::*;

  logic [31:0] slot_id_copy  [SLOTS];
  logic [15:0] slot_gen_copy [SLOTS];
  int          mark_copy;
  logic        net_mode_copy;
  rsp_t        pending_rsp_q[$];
  int          fails = 0;

  assign fail_count = fails;

  // First slot below the mark holding key, SLOTS when none.
  function automatic int first_slot_of(logic [31:0] key);
    for (int i = 0; i < mark_copy; i++) begin
      if (slot_id_copy[i] == key) return i;
    end
    return SLOTS;
  endfunction

  // Applies one command to the table copy and returns the result beat it should produce.
  function automatic rsp_t apply_slot_cmd(cmd_t c);
    rsp_t r;
    int   s;
    r.result_value    = FREE_ID;
    r.status          = ST_MISS;
    r.slot_generation = '0;
    case (c.opcode)
      OP_ADD: begin
        s = first_slot_of(FREE_ID);
        if (s < SLOTS) begin
          slot_id_copy[s]   = c.unit_id;
          slot_gen_copy[s]  = slot_gen_copy[s] + 16'd1;
          r.result_value    = 32'(s);
          r.status          = ST_OK;
          r.slot_generation = slot_gen_copy[s];
        end else if (mark_copy < SLOTS) begin
          slot_id_copy[mark_copy]  = c.unit_id;
          slot_gen_copy[mark_copy] = '0;
          r.result_value           = 32'(mark_copy);
          r.status                 = ST_OK;
          mark_copy++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_FORGET: begin
        s = first_slot_of(c.unit_id);
        if (s < SLOTS) begin
          slot_id_copy[s] = FREE_ID;
          r.result_value  = 32'(s);
          r.status        = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (!net_mode_copy) begin
          r.result_value = c.unit_id;
          r.status       = ST_OK;
        end else begin
          s = first_slot_of(c.unit_id);
          if (s < SLOTS) begin
            r.result_value = 32'(s);
            r.status       = ST_OK;
          end
        end
      end
      default: begin
        // never touches an entry at or above the mark
        if (int'(c.slot_index) < mark_copy) begin
          if (slot_id_copy[c.slot_index] != FREE_ID) begin
            r.result_value = slot_id_copy[c.slot_index];
            r.status       = ST_OK;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    fails++;
    if (fails <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      mark_copy     = 0;
      net_mode_copy = 1'b1;
      pending_rsp_q.delete();
      outstanding <= 0;
    end else begin
      // a result beat may land on the same edge as the next command beat: pop first
      if (done) begin
        if (pending_rsp_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing pending: value %h status %0d gen %h",
                                  result.result_value, result.status, result.slot_generation));
        end else begin
          want = pending_rsp_q.pop_front();
          if (result.result_value !== want.result_value)
            flag_mismatch($sformatf("result_value: expected %h, got %h",
                                    want.result_value, result.result_value));
          if (result.status !== want.status)
            flag_mismatch($sformatf("status: expected %0d, got %0d", want.status, result.status));
          if (result.slot_generation !== want.slot_generation)
            flag_mismatch($sformatf("slot_generation: expected %h, got %h",
                                    want.slot_generation, result.slot_generation));
        end
      end
      if (cfg_valid && cfg_ready) net_mode_copy = cfg_data;
      if (start && !busy) pending_rsp_q = {pending_rsp_q, apply_slot_cmd(cmd)};
      outstanding <= pending_rsp_q.size();
    end
  end

endmodule

// ===== bench/id_to_slot_mapping_table_test.sv =====
`timescale 1ns / 100ps
// Top of the id-to-slot mapping table bench: clock, reset, command and config stimulus,
// watchdog and verdict. Depends on idsm_pkg, id_to_slot_mapping_table and its checker.
module id_to_slot_mapping_table_test;
  import idsm_pkg::*;

  localparam int SLOTS       = SLOTS_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic start     = 1'b0;
  logic busy;
  cmd_t cmd       = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;
  logic done;
  rsp_t result;
  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;

  logic [31:0] id_pool [16];

  initial begin
    forever #10 clk = ~clk;
  end

  id_to_slot_mapping_table #(.SLOTS(SLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  id_to_slot_mapping_table_checker #(.SLOTS(SLOTS)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Watchdog: ends the run after too many cycles with no beat of any kind.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("id_to_slot_mapping_table_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // When gap is nonzero, drops start and waits out the gap, then presents the command until it is taken.
  // start stays high on return so a back-to-back command needs no extra edge.
  task automatic send_cmd(input op_t op, input logic [31:0] id, input logic [5:0] idx,
                          input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd   <= '{opcode: op, unit_id: id, slot_index: idx};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_net_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short gaps; some long enough to land anywhere in a full turn of the ring.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 70);
    return $urandom_range(71, 150);
  endfunction

  // Reused ids keep lookups and forgets hitting; fresh ids rotate into the pool.
  function automatic logic [31:0] pick_id();
    int          r;
    logic [31:0] fresh;
    r = $urandom_range(0, 99);
    if (r < 68) return id_pool[$urandom_range(0, 15)];
    if (r < 74) return FREE_ID;
    fresh = $urandom();
    id_pool[$urandom_range(2, 15)] = fresh;
    return fresh;
  endfunction

  initial begin
    int   n_items;
    int   add_lim;
    int   fgt_lim;
    int   lkp_lim;
    int   r;
    bit   no_gaps;
    logic mode;
    op_t  op;

    id_pool[0] = '0;
    id_pool[1] = FREE_ID;
    for (int i = 2; i < 16; i++) id_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, append, reuse of an all-ones slot, free and refree
    send_cmd(OP_LOOKUP,  32'h0000_0000, 6'd0,  0);
    send_cmd(OP_REVERSE, 32'h0000_0000, 6'd0,  0);
    send_cmd(OP_FORGET,  32'h1234_5678, 6'd0,  1);
    send_cmd(OP_FORGET,  FREE_ID,       6'd0,  0);
    send_cmd(OP_ADD,     32'h0000_0000, 6'd0,  0);
    send_cmd(OP_ADD,     FREE_ID,       6'd63, 2);
    send_cmd(OP_ADD,     32'hffff_fffe, 6'd0,  0);
    send_cmd(OP_ADD,     32'h8000_0001, 6'd0,  0);
    send_cmd(OP_LOOKUP,  32'h0000_0000, 6'd0,  0);
    send_cmd(OP_LOOKUP,  32'hffff_fffe, 6'd0,  30);
    send_cmd(OP_REVERSE, 32'h0000_0000, 6'd1,  0);
    send_cmd(OP_REVERSE, FREE_ID,       6'd63, 0);
    send_cmd(OP_FORGET,  32'h0000_0000, 6'd0,  0);
    send_cmd(OP_REVERSE, 32'h0000_0000, 6'd0,  0);
    send_cmd(OP_FORGET,  FREE_ID,       6'd0,  0);
    send_cmd(OP_ADD,     32'h0000_ffff, 6'd0,  0);
    send_cmd(OP_LOOKUP,  FREE_ID,       6'd0,  0);
    drain_results();
    write_net_mode(1'b0);
    send_cmd(OP_LOOKUP,  FREE_ID,       6'd0,  0);
    send_cmd(OP_LOOKUP,  32'h5555_aaaa, 6'd0,  0);
    send_cmd(OP_ADD,     32'h7fff_0000, 6'd0,  0);
    send_cmd(OP_REVERSE, 32'h0000_0000, 6'd2,  0);
    drain_results();
    write_net_mode(1'b1);
    send_cmd(OP_LOOKUP,  32'h0000_ffff, 6'd0,  0);
    send_cmd(OP_FORGET,  32'h8000_0001, 6'd0,  0);
    send_cmd(OP_ADD,     32'h8000_0001, 6'd0,  0);

    // random phases; the mode only changes with the block idle between phases
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin mode = 1'b1; n_items = 70;  add_lim = 60; fgt_lim = 70; lkp_lim = 85; end
        1: begin mode = 1'b1; n_items = 100; add_lim = 85; fgt_lim = 88; lkp_lim = 94; end
        2: begin mode = 1'b0; n_items = 60;  add_lim = 25; fgt_lim = 50; lkp_lim = 75; end
        3: begin mode = 1'b1; n_items = 80;  add_lim = 15; fgt_lim = 65; lkp_lim = 85; end
        4: begin mode = 1'b1; n_items = 90;  add_lim = 35; fgt_lim = 60; lkp_lim = 80; end
        5: begin mode = 1'b0; n_items = 40;  add_lim = 30; fgt_lim = 55; lkp_lim = 80; end
        default: begin mode = 1'b1; n_items = 60; add_lim = 30; fgt_lim = 55; lkp_lim = 80; end
      endcase
      no_gaps = (ph % 3 == 1);
      drain_results();
      write_net_mode(mode);
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < add_lim)      op = OP_ADD;
        else if (r < fgt_lim) op = OP_FORGET;
        else if (r < lkp_lim) op = OP_LOOKUP;
        else                  op = OP_REVERSE;
        send_cmd(op, pick_id(), 6'($urandom_range(0, SLOTS - 1)), no_gaps ? 0 : pick_gap());
      end
    end

    drain_results();
    repeat (SLOTS + 10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("id_to_slot_mapping_table_test passed");
    end else begin
      $display("id_to_slot_mapping_table_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/idsm_pkg.sv
rtl/idsm_cell.sv
rtl/id_to_slot_mapping_table.sv
bench/id_to_slot_mapping_table_checker.sv
bench/id_to_slot_mapping_table_test.sv
